/* hdl/hsfc_pkg.sv */
// Shared types and constants for the half/single float converter pipeline.
`timescale 1ns / 1ps

package hsfc_pkg;

  // Direction codes carried on the input tuser bit.
  localparam logic DIR_H2S = 1'b0;
  localparam logic DIR_S2H = 1'b1;

  // Half precision field constants.
  localparam logic [4:0] HALF_EXP_MAX  = 5'h1F;
  localparam logic [7:0] HALF_BIAS_ADJ = 8'd112;
  localparam logic [7:0] HALF_SUB_EXP  = 8'd113;

  // Single precision field constants.
  localparam logic [7:0] SGL_EXP_MAX   = 8'hFF;
  localparam logic [7:0] SGL_INF_ABOVE = 8'd142;
  localparam logic [7:0] SGL_ZERO_BELOW = 8'd103;
  localparam logic [7:0] SGL_SUB_MAX   = 8'd112;
  localparam logic [7:0] SGL_SHIFT_BASE = 8'd125;

  // Stage 1 result: fields split out, subnormal shift amount decided.
  typedef struct packed {
    logic        dir;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [23:0] man;
    logic [4:0]  shamt;
  } s1_t;

  // Stage 2 result: subnormal mantissa aligned.
  typedef struct packed {
    logic        dir;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [23:0] man;
  } s2_t;

endpackage

/* hdl/hsfc_unpack.sv */
// Stage 1: field split, operand classification and shift amount selection.
`timescale 1ns / 1ps

module hsfc_unpack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic          up_dir,
  input  logic [31:0]   up_value,
  output logic          dn_valid,
  input  logic          dn_ready,
  output hsfc_pkg::s1_t dn_data
);
  import hsfc_pkg::*;

  logic valid_r;
  s1_t  data_r;
  logic valid_nxt;
  s1_t  data_nxt;

  logic [4:0] h_exp;
  logic [9:0] h_man;
  logic [3:0] h_lz;
  logic [7:0] s_exp;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  assign h_exp = up_value[14:10];
  assign h_man = up_value[9:0];
  assign s_exp = up_value[30:23];

  // Shifts needed to bring the top set bit of a half subnormal to the hidden bit.
  always_comb begin
    h_lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        h_lz = 4'(10 - i);
      end
    end
  end

  always_comb begin
    data_nxt       = '0;
    data_nxt.dir   = up_dir;
    if (up_dir == DIR_H2S) begin
      data_nxt.sign = up_value[15];
      if (h_exp == 5'd0) begin
        if (h_man != 10'd0) begin
          data_nxt.sub   = 1'b1;
          data_nxt.man   = {14'd0, h_man};
          data_nxt.shamt = {1'b0, h_lz};
        end
      end else if (h_exp == HALF_EXP_MAX) begin
        data_nxt.exp = SGL_EXP_MAX;
        data_nxt.man = {1'b0, h_man, 13'd0};
      end else begin
        data_nxt.exp = {3'd0, h_exp} + HALF_BIAS_ADJ;
        data_nxt.man = {1'b0, h_man, 13'd0};
      end
    end else begin
      data_nxt.sign = up_value[31];
      if (s_exp > SGL_INF_ABOVE) begin
        // Overflow and NaN both saturate to infinity.
        data_nxt.exp = {3'd0, HALF_EXP_MAX};
      end else if (s_exp < SGL_ZERO_BELOW) begin
        data_nxt.exp = 8'd0;
      end else if (s_exp <= SGL_SUB_MAX) begin
        data_nxt.sub   = 1'b1;
        data_nxt.man   = {1'b1, up_value[22:0]};
        data_nxt.shamt = 5'(SGL_SHIFT_BASE - s_exp);
      end else begin
        data_nxt.exp = s_exp - SGL_SUB_MAX;
        data_nxt.man = {14'd0, up_value[22:13]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hdl/hsfc_align.sv */
// Stage 2: mantissa alignment for subnormal operands and results.
`timescale 1ns / 1ps

module hsfc_align (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  hsfc_pkg::s1_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output hsfc_pkg::s2_t dn_data
);
  import hsfc_pkg::*;

  logic valid_r;
  s2_t  data_r;
  logic valid_nxt;
  s2_t  data_nxt;

  logic [19:0] norm_w;
  logic [23:0] trunc_w;

  assign up_ready  = !valid_r || dn_ready;
  assign dn_valid  = valid_r;
  assign dn_data   = data_r;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // Half subnormal: shift left until the hidden bit position is reached.
  assign norm_w  = {10'd0, up_data.man[9:0]} << up_data.shamt;
  // Single to half subnormal: keep one extra bit below the result for rounding.
  assign trunc_w = up_data.man >> up_data.shamt;

  always_comb begin
    data_nxt.dir  = up_data.dir;
    data_nxt.sign = up_data.sign;
    data_nxt.sub  = up_data.sub;
    data_nxt.exp  = up_data.exp;
    data_nxt.man  = up_data.man;
    if (up_data.sub) begin
      if (up_data.dir == DIR_H2S) begin
        data_nxt.exp = HALF_SUB_EXP - {3'd0, up_data.shamt};
        data_nxt.man = {1'b0, norm_w[9:0], 13'd0};
      end else begin
        data_nxt.man = trunc_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hdl/hsfc_pack.sv */
// Stage 3: rounding of half subnormals and result assembly into the output register.
`timescale 1ns / 1ps

module hsfc_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  hsfc_pkg::s2_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [31:0]   dn_value
);
  import hsfc_pkg::*;

  logic        valid_r;
  logic [31:0] value_r;
  logic        valid_nxt;
  logic [31:0] value_nxt;
  logic [11:0] rnd_sum;

  assign up_ready  = !valid_r || dn_ready;
  assign dn_valid  = valid_r;
  assign dn_value  = value_r;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // Round half up; a carry into bit 10 lands on the smallest normal exponent.
  assign rnd_sum = {1'b0, up_data.man[10:0]} + 12'd1;

  always_comb begin
    if (up_data.dir == DIR_H2S) begin
      value_nxt = {up_data.sign, up_data.exp, up_data.man[22:0]};
    end else if (up_data.sub) begin
      value_nxt = {16'd0, up_data.sign, 4'd0, rnd_sum[11:1]};
    end else begin
      value_nxt = {16'd0, up_data.sign, up_data.exp[4:0], up_data.man[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      value_r <= value_nxt;
    end
  end

endmodule

/* hdl/half_single_float_converter_unit.sv */
// Top level of the half/single precision float converter pipeline.
//
// Each request on the in_ channel carries one operand in in_tdata and the
// conversion direction in in_tuser (0 = half to single, 1 = single to half;
// a half operand uses bits 15..0). Each request gives exactly one result on
// the out_ channel; a half result sits in bits 15..0 with the upper half zero.
// The datapath is three register stages: field split and classification,
// mantissa alignment, then rounding and packing into the output register.
// A request passes through the field split, alignment and output registers in
// that order before out_tvalid rises, and one request can be taken every
// cycle while out_tready stays high. Each stage holds its item while the next
// stage is full, so a stalled receiver fills the pipeline and then drops
// in_tready; nothing is lost or repeated. in_tready is high whenever the
// output register is empty. A synchronous reset (rst_n low) empties all
// stages; the block keeps no other state.
`timescale 1ns / 1ps

module half_single_float_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value_in[31:0]
  input  logic        in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // value_out[31:0]
);
  import hsfc_pkg::*;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  hsfc_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_dir   (in_tuser),
    .up_value (in_tdata),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  hsfc_align u_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  hsfc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_value (out_tdata)
  );

  // An empty output register means every stage can advance.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output register is empty");

  // Requests are refused only when all three stages are full and stalled.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && s2_valid && out_tvalid && !out_tready))
    else $error("input stalled with room in the pipeline");

  // A stage 1 item blocked by stage 2 keeps its contents.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_data)))
    else $error("stage 1 item changed while stalled");

  // A stage 2 item blocked by the output register keeps its contents.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_data)))
    else $error("stage 2 item changed while stalled");

endmodule
